// File: hdl/cct_pkg.sv
// cct_pkg: shared types, constants and calendar functions for the
// calendar clock. No dependencies; imported by cct_next and calendar_clock_tick.
`default_nettype none

package cct_pkg;

  // command codes
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SET  = 1'b1;

  // counter limits
  localparam logic [5:0]  SEC_LAST   = 6'd59;
  localparam logic [5:0]  MIN_LAST   = 6'd59;
  localparam logic [4:0]  HOUR_LAST  = 5'd23;
  localparam logic [3:0]  MONTH_LAST = 4'd12;
  localparam logic [13:0] YEAR_FIRST = 14'd1000;
  localparam logic [13:0] YEAR_LAST  = 14'd9999;
  localparam logic [4:0]  HOUR_NOON  = 5'd12;
  localparam logic [3:0]  TWELVE     = 4'd12;

  // reset date: January 1, 2000, midnight
  localparam logic [13:0] YEAR_RST = 14'd2000;

  // divisibility by 25: y * inv(25) mod 2^16 lands at or below 65535/25
  localparam logic [15:0] INV25     = 16'd23593;
  localparam logic [15:0] DIV25_LIM = 16'd2621;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_BAD_MONTH = 3'd1,
    STAT_BAD_YEAR  = 3'd2,
    STAT_BAD_DAY   = 3'd3,
    STAT_BAD_HOUR  = 3'd4,
    STAT_BAD_MIN   = 3'd5,
    STAT_BAD_SEC   = 3'd6
  } status_t;

  typedef struct packed {
    logic        func;
    logic [3:0]  new_month;
    logic [13:0] new_year;
    logic [4:0]  new_day;
    logic [4:0]  new_hour;
    logic [5:0]  new_minute;
    logic [5:0]  new_second;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [13:0] cur_year;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic [5:0]  cur_second;
    logic [3:0]  hour_twelve;
    logic        is_pm;
    logic [2:0]  status;
    logic        year_wrapped;
  } res_t;

  // time-of-day and date state
  typedef struct packed {
    logic [3:0]  month;
    logic [4:0]  day;
    logic [13:0] year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } tod_t;

  function automatic logic leap_year(logic [13:0] y);
    logic [31:0] prod;
    logic        by25;
    prod = 32'(y) * 32'(INV25);
    by25 = (prod[15:0] <= DIV25_LIM);
    // div by 4 but not 100, or div by 400 (= div by 16 and by 25)
    return ((y[1:0] == 2'd0) && !by25) || ((y[3:0] == 4'd0) && by25);
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] m, logic [13:0] y);
    logic [4:0] len;
    unique case (m)
      4'd2:                      len = leap_year(y) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// File: hdl/cct_next.sv
// cct_next: next date/time and result beat for one command.
// Pure combinational; depends on cct_pkg.
`default_nettype none

module cct_next (
  input  var cct_pkg::cmd_t cmd,
  input  var cct_pkg::tod_t cur,
  output var cct_pkg::tod_t nxt,
  output var cct_pkg::res_t res
);
  import cct_pkg::*;

  status_t st;
  logic    wrap;
  tod_t    tick;
  tod_t    tnew;

  // one-second advance with carries
  always_comb begin
    tick = cur;
    wrap = 1'b0;
    if (cur.second >= SEC_LAST) begin
      tick.second = '0;
      if (cur.minute >= MIN_LAST) begin
        tick.minute = '0;
        if (cur.hour >= HOUR_LAST) begin
          tick.hour = '0;
          if (cur.day < month_len(cur.month, cur.year)) begin
            tick.day = cur.day + 5'd1;
          end else begin
            tick.day = 5'd1;
            if (cur.month < MONTH_LAST) begin
              tick.month = cur.month + 4'd1;
            end else begin
              tick.month = 4'd1;
              if (cur.year >= YEAR_LAST) begin
                tick.year = YEAR_FIRST;
                wrap      = 1'b1;
              end else begin
                tick.year = cur.year + 14'd1;
              end
            end
          end
        end else begin
          tick.hour = cur.hour + 5'd1;
        end
      end else begin
        tick.minute = cur.minute + 6'd1;
      end
    end else begin
      tick.second = cur.second + 6'd1;
    end
  end

  // set: first failing field wins
  always_comb begin
    tnew = '{month: cmd.new_month, day: cmd.new_day, year: cmd.new_year,
             hour: cmd.new_hour, minute: cmd.new_minute, second: cmd.new_second};
    priority if (cmd.new_month == 4'd0 || cmd.new_month > MONTH_LAST)
      st = STAT_BAD_MONTH;
    else if (cmd.new_year < YEAR_FIRST || cmd.new_year > YEAR_LAST)
      st = STAT_BAD_YEAR;
    else if (cmd.new_day == 5'd0 ||
             cmd.new_day > month_len(cmd.new_month, cmd.new_year))
      st = STAT_BAD_DAY;
    else if (cmd.new_hour > HOUR_LAST)
      st = STAT_BAD_HOUR;
    else if (cmd.new_minute > MIN_LAST)
      st = STAT_BAD_MIN;
    else if (cmd.new_second > SEC_LAST)
      st = STAT_BAD_SEC;
    else
      st = STAT_OK;
  end

  always_comb begin
    if (cmd.func == FUNC_SET) begin
      nxt = (st == STAT_OK) ? tnew : cur;
    end else begin
      nxt = tick;
    end

    res.cur_month    = nxt.month;
    res.cur_day      = nxt.day;
    res.cur_year     = nxt.year;
    res.cur_hour     = nxt.hour;
    res.cur_minute   = nxt.minute;
    res.cur_second   = nxt.second;
    // hour stays in 0..23, so mod 12 is a single subtract
    if (nxt.hour == 5'd0) begin
      res.hour_twelve = TWELVE;
    end else if (nxt.hour > HOUR_NOON) begin
      res.hour_twelve = 4'(nxt.hour - HOUR_NOON);
    end else begin
      res.hour_twelve = nxt.hour[3:0];
    end
    res.is_pm        = (nxt.hour >= HOUR_NOON);
    res.status       = (cmd.func == FUNC_SET) ? st : STAT_OK;
    res.year_wrapped = (cmd.func == FUNC_TICK) && wrap;
  end

endmodule

`default_nettype wire

// File: hdl/calendar_clock_tick.sv
// calendar_clock_tick: Gregorian real-time clock/calendar, top level.
// Depends on cct_pkg and cct_next.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   cmd     | in        | cmd_valid/cmd_stall  | cct_pkg::cmd_t (tick or set)
//   res     | out       | res_valid/res_stall  | cct_pkg::res_t (date, status)
//
// One beat per clock in both directions unless a stalled result holds the
// flow. A command beat lands in the command register, and its result then
// moves into the result register. The only per-beat work is cct_next
// (carry chain, leap test with one small multiply).
// rst (synchronous) gives 2000-01-01 00:00:00 with both registers empty.
// A stalled result holds the command register; cmd_stall rises only then.
`default_nettype none

module calendar_clock_tick (
  input  var logic           clk,
  input  var logic           rst,
  input  var logic           cmd_valid,
  output var logic           cmd_stall,
  input  var cct_pkg::cmd_t  cmd,
  output var logic           res_valid,
  input  var logic           res_stall,
  output var cct_pkg::res_t  res
);
  import cct_pkg::*;

  // command register
  logic cmd_q_valid;
  cmd_t cmd_q;

  // clock/calendar state
  tod_t tm;
  tod_t tm_next;
  res_t res_next;

  logic advance;   // command register moves into result register
  logic take;      // command beat accepted

  assign advance   = cmd_q_valid && (!res_valid || !res_stall);
  assign cmd_stall = cmd_q_valid && !advance;
  assign take      = cmd_valid && !cmd_stall;

  cct_next u_next (
    .cmd (cmd_q),
    .cur (tm),
    .nxt (tm_next),
    .res (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q_valid <= 1'b0;
    end else if (take) begin
      cmd_q_valid <= 1'b1;
    end else if (advance) begin
      cmd_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_q <= cmd;
    end
  end

  // state register: advances once per command
  always_ff @(posedge clk) begin
    if (rst) begin
      tm <= '{month: 4'd1, day: 5'd1, year: YEAR_RST,
              hour: '0, minute: '0, second: '0};
    end else if (advance) begin
      tm <= tm_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  // ---- assertions ----

  // a finished command always shows up as a result next cycle
  a_adv_res: assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("result missing after command advanced");

  // input back-pressure only comes from a full, stalled output
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> (res_valid && res_stall && cmd_q_valid))
    else $error("cmd_stall without a stalled result");

  // a rejected set leaves the time alone
  a_bad_set: assert property (@(posedge clk) disable iff (rst)
    (advance && res_next.status != STAT_OK) |=> (tm == $past(tm)))
    else $error("time changed on a failed set");

  // state stays within calendar range
  a_range: assert property (@(posedge clk) disable iff (rst)
    (tm.month >= 4'd1 && tm.month <= MONTH_LAST && tm.day >= 5'd1 &&
     tm.hour <= HOUR_LAST && tm.minute <= MIN_LAST && tm.second <= SEC_LAST &&
     tm.year >= YEAR_FIRST && tm.year <= YEAR_LAST))
    else $error("clock state out of range");

endmodule

`default_nettype wire
